/* hw/rtl/bers_pkg.sv */
// ----------------------------------------------------------------------------
// Box edge ray sweep package
// Shared constants, request and response payloads, and the control groups
// that pass between the sweep controller, the serial divider and the fan scan.
// ----------------------------------------------------------------------------
`default_nettype none

package bers_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_RAYS   = 16;
    localparam int NRAY_BITS  = 5;

    // Offsets along the sweep axis need two bits beyond a coordinate.
    localparam int DIFF_BITS  = COORD_BITS + 2;
    localparam int MAG_BITS   = DIFF_BITS - 1;
    localparam int DVD_BITS   = MAG_BITS + FRAC_BITS;
    localparam int QUO_BITS   = DVD_BITS + 2;
    localparam int CNT_BITS   = $clog2(DVD_BITS + 1);

    // Fan bounds relative to the moving box min, and their scaled forms.
    localparam int OFF_BITS   = COORD_BITS + 3;
    localparam int RIDX_BITS  = $clog2(MAX_RAYS);
    localparam int SCL_BITS   = OFF_BITS + RIDX_BITS + 2;
    localparam int ACC_BITS   = SIZE_BITS + RIDX_BITS + 1;

    typedef struct packed {
        logic                         op;
        logic                         near_side;
        logic signed [COORD_BITS-1:0] source_x;
        logic signed [COORD_BITS-1:0] source_y;
        logic [SIZE_BITS-1:0]         source_w;
        logic [SIZE_BITS-1:0]         source_h;
        logic signed [COORD_BITS-1:0] dest_x;
        logic signed [COORD_BITS-1:0] dest_y;
        logic [SIZE_BITS-1:0]         dest_w;
        logic [SIZE_BITS-1:0]         dest_h;
        logic signed [COORD_BITS-1:0] ray_length;
    } bers_req_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] diff_x;
        logic signed [COORD_BITS-1:0] diff_y;
    } bers_rsp_t;

    typedef struct packed {
        logic                  start;
        logic [DVD_BITS-1:0]   dividend;
        logic [COORD_BITS-1:0] divisor;
    } bers_div_req_t;

    typedef struct packed {
        logic                done;
        logic [DVD_BITS-1:0] quo;
        logic                rem_nz;
    } bers_div_rsp_t;

    typedef struct packed {
        logic                       start;
        logic [NRAY_BITS-1:0]       nrays;
        logic [SIZE_BITS-1:0]       size;
        logic signed [OFF_BITS-1:0] lo_off;
        logic signed [OFF_BITS-1:0] hi_off;
    } bers_fan_req_t;

    typedef struct packed {
        logic busy;
        logic any;
    } bers_fan_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/bers_if.sv */
// ----------------------------------------------------------------------------
// Box edge ray sweep channels
// Valid/ready channels for requests, responses and the ray count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface bers_req_if;
    import bers_pkg::*;
    logic      valid;
    logic      ready;
    bers_req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bers_rsp_if;
    import bers_pkg::*;
    logic      valid;
    logic      ready;
    bers_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bers_cfg_if;
    import bers_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [NRAY_BITS-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bers_div.sv */
// ----------------------------------------------------------------------------
// Box edge ray sweep serial divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bers_div
    import bers_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  bers_div_req_t req,
    output bers_div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [DVD_BITS-1:0]   sh_reg, sh_next;
    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [COORD_BITS-1:0] dv_reg, dv_next;
    logic [COORD_BITS:0]   trial;
    logic                  qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        // The dividend leaves the shift register from the top while the
        // quotient bits enter at the bottom.
        trial = {rem_reg[COORD_BITS-1:0], sh_reg[DVD_BITS-1]};
        qbit  = (trial >= {1'b0, dv_reg});
        if (busy_reg)
        begin
            rem_next = qbit ? (trial - {1'b0, dv_reg}) : trial;
            sh_next  = {sh_reg[DVD_BITS-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DVD_BITS);
            sh_next   = req.dividend;
            rem_next  = '0;
            dv_next   = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.quo    = sh_reg;
    assign rsp.rem_nz = (rem_reg != '0);

endmodule

`default_nettype wire

/* hw/rtl/bers_fan.sv */
// ----------------------------------------------------------------------------
// Box edge ray sweep fan scan
// Walks the rays across the fan axis, one ray per cycle, and reports whether
// any ray origin lies inside the target box span on that axis.
// ----------------------------------------------------------------------------
`default_nettype none

module bers_fan
    import bers_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  bers_fan_req_t req,
    output bers_fan_rsp_t rsp
);

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SCALE,
        FS_SCAN
    } fan_state_t;

    fan_state_t                 state_reg, state_next;
    logic                       any_reg, any_next;
    logic [RIDX_BITS-1:0]       ridx_reg, ridx_next;
    logic [RIDX_BITS-1:0]       last_reg, last_next;
    logic [ACC_BITS-1:0]        acc_reg, acc_next;
    logic [NRAY_BITS-1:0]       n_reg, n_next;
    logic [SIZE_BITS-1:0]       size_reg, size_next;
    logic signed [OFF_BITS-1:0] lo_reg, lo_next;
    logic signed [OFF_BITS-1:0] hi_reg, hi_next;
    logic signed [SCL_BITS-1:0] lom_reg, lom_next;
    logic signed [SCL_BITS-1:0] him_reg, him_next;
    logic [NRAY_BITS-1:0]       span;
    logic signed [SCL_BITS-1:0] acc_s;

    // A ray at step k sits inside when lo <= floor(k*size/span) <= hi, which
    // holds exactly when lo*span <= k*size < (hi+1)*span.
    always_comb
    begin
        state_next = state_reg;
        any_next   = any_reg;
        ridx_next  = ridx_reg;
        last_next  = last_reg;
        acc_next   = acc_reg;
        n_next     = n_reg;
        size_next  = size_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        lom_next   = lom_reg;
        him_next   = him_reg;
        span       = n_reg - 1'b1;
        acc_s      = $signed({{(SCL_BITS-ACC_BITS){1'b0}}, acc_reg});
        case (state_reg)
            FS_IDLE:
            begin
                if (req.start)
                begin
                    n_next     = req.nrays;
                    size_next  = req.size;
                    lo_next    = req.lo_off;
                    hi_next    = req.hi_off;
                    state_next = FS_SCALE;
                end
            end
            FS_SCALE:
            begin
                lom_next  = SCL_BITS'(lo_reg) * $signed({1'b0, span});
                him_next  = (SCL_BITS'(hi_reg) + SCL_BITS'(1)) * $signed({1'b0, span});
                ridx_next = '0;
                last_next = span[RIDX_BITS-1:0];
                acc_next  = '0;
                if (n_reg == '0)
                begin
                    any_next   = 1'b0;
                    state_next = FS_IDLE;
                end
                else if (n_reg == NRAY_BITS'(1))
                begin
                    any_next   = (lo_reg <= 0) && (hi_reg >= 0);
                    state_next = FS_IDLE;
                end
                else
                begin
                    any_next   = 1'b0;
                    state_next = FS_SCAN;
                end
            end
            FS_SCAN:
            begin
                if ((acc_s >= lom_reg) && (acc_s < him_reg))
                begin
                    any_next = 1'b1;
                end
                acc_next  = acc_reg + ACC_BITS'(size_reg);
                ridx_next = ridx_reg + 1'b1;
                if (ridx_reg == last_reg)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            any_reg   <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;
        last_reg <= last_next;
        acc_reg  <= acc_next;
        n_reg    <= n_next;
        size_reg <= size_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        lom_reg  <= lom_next;
        him_reg  <= him_next;
    end

    assign rsp.busy = (state_reg != FS_IDLE);
    assign rsp.any  = any_reg;

endmodule

`default_nettype wire

/* hw/rtl/box_edge_ray_sweep_collision.sv */
// ----------------------------------------------------------------------------
// Box edge ray sweep collision
// Casts a fan of parallel rays from one edge of a moving box and clips them
// against a target box, reporting a hit and the offset to the entry point.
// ----------------------------------------------------------------------------
// The block takes one request at a time. For a nonzero ray length the two
// slab fractions on the sweep axis come from a shared bit-serial divider at
// one quotient bit per cycle, the second division launched as soon as the
// first finishes, and the fan scan over up to sixteen rays runs beside the
// first division, one ray per cycle. The evaluate, multiply and load states
// then evaluate the hit, scale the entry offset and load the output register.
// For a zero ray length the divider is skipped and the evaluation waits only
// for the fan scan, whose ray count is capped at sixteen. A finished response
// sits in an output register, so a new request is accepted while the previous
// response waits to be taken.
// The ray count register may be written at any time the block is idle; a
// value above sixteen casts sixteen rays and zero casts none.
`default_nettype none

module box_edge_ray_sweep_collision
    import bers_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bers_req_if.sink   req,
    bers_rsp_if.source rsp,
    bers_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIVA,
        ST_DIVB,
        ST_EVAL,
        ST_MUL,
        ST_LOAD
    } state_t;

    localparam logic signed [QUO_BITS-1:0] ONE_Q = QUO_BITS'(1) <<< FRAC_BITS;
    localparam int PROD_BITS = COORD_BITS + FRAC_BITS + 2;

    state_t                      state_reg, state_next;
    bers_req_t                   item_reg, item_next;
    logic [NRAY_BITS-1:0]        num_rays_reg, num_rays_next;
    logic signed [QUO_BITS-1:0]  qa_reg, qa_next;
    logic signed [QUO_BITS-1:0]  qb_reg, qb_next;
    logic                        hit_reg, hit_next;
    logic [FRAC_BITS:0]          flo_reg, flo_next;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic                        out_valid_reg, out_valid_next;
    bers_rsp_t                   out_data_reg, out_data_next;

    bers_div_req_t div_req;
    bers_div_rsp_t div_rsp;
    bers_fan_req_t fan_req;
    bers_fan_rsp_t fan_rsp;

    // Geometry chosen by the sweep axis: s is the sweep axis, f the fan axis.
    logic signed [COORD_BITS:0]    os;
    logic signed [COORD_BITS:0]    lo_s, hi_s;
    logic signed [DIFF_BITS-1:0]   diff_a, diff_b, diff_sel;
    logic [MAG_BITS-1:0]           mag_sel;
    logic [COORD_BITS-1:0]         len_mag;
    logic                          len_zero;
    logic signed [QUO_BITS-1:0]    q_mag, q_signed;
    logic                          q_neg;
    logic signed [QUO_BITS-1:0]    qmin, qmax, fl, fh;
    logic                          sweep_ok;
    logic [COORD_BITS-1:0]         diff_s;
    logic signed [COORD_BITS-1:0]  s_min, f_min, d_s, d_f;
    logic [SIZE_BITS-1:0]          s_size, f_size, ds_size, df_size;
    logic [NRAY_BITS-1:0]          n_eff;

    always_comb
    begin
        s_min   = item_reg.op ? item_reg.source_x : item_reg.source_y;
        f_min   = item_reg.op ? item_reg.source_y : item_reg.source_x;
        s_size  = item_reg.op ? item_reg.source_w : item_reg.source_h;
        f_size  = item_reg.op ? item_reg.source_h : item_reg.source_w;
        d_s     = item_reg.op ? item_reg.dest_x : item_reg.dest_y;
        d_f     = item_reg.op ? item_reg.dest_y : item_reg.dest_x;
        ds_size = item_reg.op ? item_reg.dest_w : item_reg.dest_h;
        df_size = item_reg.op ? item_reg.dest_h : item_reg.dest_w;

        // Every ray starts on the chosen edge of the sweep axis.
        os   = (COORD_BITS+1)'(s_min)
               + (item_reg.near_side ? '0 : $signed({2'b00, s_size}));
        lo_s = (COORD_BITS+1)'(d_s);
        hi_s = (COORD_BITS+1)'(d_s) + $signed({2'b00, ds_size});

        diff_a   = DIFF_BITS'(lo_s) - DIFF_BITS'(os);
        diff_b   = DIFF_BITS'(hi_s) - DIFF_BITS'(os);
        len_zero = (item_reg.ray_length == '0);
        len_mag  = item_reg.ray_length[COORD_BITS-1] ? COORD_BITS'(-item_reg.ray_length)
                                                    : item_reg.ray_length;

        // The first division is launched from the start state, the second
        // as soon as the first one finishes.
        diff_sel = (state_reg == ST_START) ? diff_a : diff_b;
        mag_sel  = diff_sel[DIFF_BITS-1] ? MAG_BITS'(-diff_sel) : MAG_BITS'(diff_sel);

        // Floor division: a negative quotient with a remainder rounds down.
        // The sign combines the numerator of the division that just finished with the ray length sign.
        q_neg    = ((state_reg == ST_DIVA) ? diff_a[DIFF_BITS-1] : diff_b[DIFF_BITS-1])
                   ^ item_reg.ray_length[COORD_BITS-1];
        q_mag    = $signed({2'b00, div_rsp.quo});
        q_signed = q_neg ? (-q_mag - QUO_BITS'(div_rsp.rem_nz)) : q_mag;

        qmin = (qa_reg < qb_reg) ? qa_reg : qb_reg;
        qmax = (qa_reg < qb_reg) ? qb_reg : qa_reg;
        fl   = (qmin > 0) ? qmin : '0;
        fh   = (qmax < ONE_Q) ? qmax : ONE_Q;
        if (len_zero)
        begin
            // A zero length segment only passes when its origin is inside.
            sweep_ok = (lo_s <= os) && (os <= hi_s);
        end
        else
        begin
            sweep_ok = !(qmax < 0) && !(qmin > ONE_Q) && (fl <= fh) && (fl < ONE_Q);
        end

        n_eff = (num_rays_reg > NRAY_BITS'(MAX_RAYS)) ? NRAY_BITS'(MAX_RAYS)
                                                      : num_rays_reg;
        diff_s = prod_reg[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
    end

    assign div_req.start    = ((state_reg == ST_START) && !len_zero)
                              || ((state_reg == ST_DIVA) && div_rsp.done);
    assign div_req.dividend = {mag_sel, {FRAC_BITS{1'b0}}};
    assign div_req.divisor  = len_mag;

    assign fan_req.start  = (state_reg == ST_START);
    assign fan_req.nrays  = n_eff;
    assign fan_req.size   = f_size;
    assign fan_req.lo_off = OFF_BITS'(d_f) - OFF_BITS'(f_min);
    assign fan_req.hi_off = OFF_BITS'(d_f) + $signed({4'b0000, df_size}) - OFF_BITS'(f_min);

    bers_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bers_fan u_fan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fan_req),
        .rsp   (fan_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        num_rays_next  = num_rays_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        hit_next       = hit_reg;
        flo_next       = flo_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg.valid)
        begin
            num_rays_next = cfg.data;
        end
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.data;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                qa_next    = '0;
                qb_next    = '0;
                state_next = len_zero ? ST_EVAL : ST_DIVA;
            end
            ST_DIVA:
            begin
                if (div_rsp.done)
                begin
                    qa_next    = q_signed;
                    state_next = ST_DIVB;
                end
            end
            ST_DIVB:
            begin
                if (div_rsp.done)
                begin
                    qb_next    = q_signed;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!fan_rsp.busy)
                begin
                    hit_next   = sweep_ok && fan_rsp.any;
                    flo_next   = len_zero ? '0 : fl[FRAC_BITS:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_BITS'(item_reg.ray_length)
                             * $signed({1'b0, flo_reg});
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.hit    = hit_reg;
                    out_data_next.diff_x = (hit_reg && item_reg.op) ? diff_s : '0;
                    out_data_next.diff_y = (hit_reg && !item_reg.op) ? diff_s : '0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_rays_reg  <= NRAY_BITS'(3);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            num_rays_reg  <= num_rays_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        qa_reg       <= qa_next;
        qb_reg       <= qb_next;
        hit_reg      <= hit_next;
        flo_reg      <= flo_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // A miss always reports a zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.hit |-> rsp.data.diff_x == '0 && rsp.data.diff_y == '0)
        else $error("miss response carries a nonzero offset");

    // The divider only finishes while the controller waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIVA || state_reg == ST_DIVB)
        else $error("divider finished outside a division state");

    // Loading the output register always presents a response next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD && state_next == ST_IDLE |=> rsp.valid)
        else $error("response lost on load");

    // The fan scan is never restarted while it is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        fan_req.start |-> !fan_rsp.busy)
        else $error("fan scan restarted while busy");

endmodule

`default_nettype wire
